FILE: hw/rtl/art_pkg.sv
// Package for the adaptive range tracker.
// Holds the shared width defaults and the margin register constants.
// No dependencies.
package art_pkg;

  // Default width of the tracked values.
  localparam int VALUE_BITS_DEF = 16;

  // Width and reset value of the initial margin register.
  localparam int MARGIN_BITS = 8;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 8'd5;

endpackage

FILE: hw/rtl/art_if.sv
// Channel interfaces of the adaptive range tracker.
// art_in_if carries input items and art_out_if carries results.
// Depends on art_pkg for the default value width.
interface art_in_if #(
  parameter int W = art_pkg::VALUE_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic         is_interval;
  logic [W-1:0] first_value;
  logic [W-1:0] second_value;
  logic         end_of_set;

  modport source (
    output valid, is_interval, first_value, second_value, end_of_set,
    input  ready
  );
  modport sink (
    input  valid, is_interval, first_value, second_value, end_of_set,
    output ready
  );
endinterface

interface art_out_if #(
  parameter int W = art_pkg::VALUE_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] range_low;
  logic [W-1:0] range_high;
  logic         is_zero;
  logic         invalid;
  logic         set_done;

  modport source (
    output valid, range_low, range_high, is_zero, invalid, set_done,
    input  ready
  );
  modport sink (
    input  valid, range_low, range_high, is_zero, invalid, set_done,
    output ready
  );
endinterface

FILE: hw/rtl/adaptive_range_tracker_top.sv
// A result is registered at its input transfer, in the skid register on an output stall.
// Throughput: one item per cycle; a skid register takes one more result while the
// output stalls, so input ready drops only when both result registers are full.
// Reset (rst, synchronous, active high) clears the running range, the set flags and
// both result valid bits, and loads the initial margin with its default of 5.
module adaptive_range_tracker_top #(
  parameter int VALUE_BITS = art_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [art_pkg::MARGIN_BITS-1:0] cfg_wdata,
  art_in_if.sink                         in_ch,
  art_out_if.source                      out_ch
);
  import art_pkg::*;

  localparam int W = VALUE_BITS;

  // Configuration register.
  logic [MARGIN_BITS-1:0] initial_margin;

  // Running state of the current set.
  logic [W-1:0] track_low;
  logic [W-1:0] track_high;
  logic         in_set;
  logic         set_failed;

  // Output register and skid register.
  logic         out_valid;
  logic [W-1:0] out_low;
  logic [W-1:0] out_high;
  logic         out_zero;
  logic         out_bad;
  logic         out_done;
  logic         skid_valid;
  logic [W-1:0] skid_low;
  logic [W-1:0] skid_high;
  logic         skid_zero;
  logic         skid_bad;
  logic         skid_done;

  // Next state and the result of the item at the input.
  logic [W-1:0] track_low_next;
  logic [W-1:0] track_high_next;
  logic         fail_next;
  logic [W-1:0] res_low;
  logic [W-1:0] res_high;
  logic         res_zero;

  // Intermediate arithmetic.
  logic [W-1:0] val;
  logic [W-1:0] upper;
  logic [W:0]   first_sum;
  logic [W-1:0] deg_dist;
  logic [W-1:0] deg_half;
  logic [W:0]   deg_sum;
  logic [W-1:0] below_dist;
  logic [W-1:0] above_dist;
  logic [W:0]   above_sum;
  logic         bad_interval;

  logic xfer_in;
  logic xfer_out;

  assign xfer_in  = in_ch.valid && in_ch.ready;
  assign xfer_out = out_valid && out_ch.ready;

  // Input is held off only when the skid register is occupied.
  assign in_ch.ready = !skid_valid;

  assign val   = in_ch.first_value;
  assign upper = in_ch.second_value;
  assign bad_interval = in_ch.is_interval && (val >= upper);

  // Range update for one item: intervals cover themselves, the first value opens a
  // window of the margin, later values push a side out by twice their distance, and
  // a single point spreads half the distance above it and below min(point, value).
  always_comb begin
    first_sum  = {1'b0, val} + (W+1)'(initial_margin);
    deg_dist   = (val < track_low) ? (track_low - val) : (val - track_low);
    deg_half   = deg_dist >> 1;
    deg_sum    = {1'b0, track_high} + {1'b0, deg_half};
    below_dist = track_low - val;
    above_dist = val - track_high;
    above_sum  = {1'b0, val} + {1'b0, above_dist};

    track_low_next  = track_low;
    track_high_next = track_high;
    fail_next       = set_failed || bad_interval;

    if (!set_failed && !bad_interval) begin
      if (in_ch.is_interval) begin
        if (!in_set) begin
          track_low_next  = val;
          track_high_next = upper;
        end else begin
          if (val < track_low) begin
            track_low_next = val;
          end
          if (upper > track_high) begin
            track_high_next = upper;
          end
        end
      end else if (!in_set) begin
        track_low_next  = (val >= W'(initial_margin)) ? (val - W'(initial_margin)) : '0;
        track_high_next = first_sum[W] ? '1 : first_sum[W-1:0];
      end else if ((track_low == track_high) && (val != track_low)) begin
        if (val < track_low) begin
          track_low_next = (val >= deg_half) ? (val - deg_half) : '0;
        end else begin
          track_low_next = (track_low >= deg_half) ? (track_low - deg_half) : '0;
        end
        track_high_next = deg_sum[W] ? '1 : deg_sum[W-1:0];
      end else if (val < track_low) begin
        track_low_next = (val >= below_dist) ? (val - below_dist) : '0;
      end else if (val > track_high) begin
        track_high_next = above_sum[W] ? '1 : above_sum[W-1:0];
      end
    end
  end

  // Finalize the range that this item leaves behind.
  always_comb begin
    res_low  = '0;
    res_high = '0;
    res_zero = 1'b0;
    if (fail_next) begin
      res_low  = '0;
    end else if ((track_low_next == '0) && (track_high_next == '0)) begin
      res_zero = 1'b1;
    end else if (track_low_next == track_high_next) begin
      res_low  = track_low_next - W'(1);
      res_high = (track_high_next == '1) ? '1 : (track_high_next + W'(1));
    end else begin
      res_low  = track_low_next;
      res_high = track_high_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_margin <= MARGIN_RESET;
    end else if (cfg_we) begin
      initial_margin <= cfg_wdata;
    end
  end

  // Set state advances on every input transfer; the end of a set clears the flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      track_low  <= '0;
      track_high <= '0;
      in_set     <= 1'b0;
      set_failed <= 1'b0;
    end else if (xfer_in) begin
      track_low  <= track_low_next;
      track_high <= track_high_next;
      if (in_ch.end_of_set) begin
        in_set     <= 1'b0;
        set_failed <= 1'b0;
      end else begin
        in_set     <= in_set || !fail_next;
        set_failed <= fail_next;
      end
    end
  end

  // Result valid bits. The skid register only fills while the output register holds
  // a result that is not being taken, and it drains into the output register first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (xfer_out) begin
        out_valid  <= skid_valid || xfer_in;
        skid_valid <= 1'b0;
      end else if (xfer_in) begin
        out_valid  <= 1'b1;
        skid_valid <= out_valid;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (xfer_out && skid_valid) begin
      out_low  <= skid_low;
      out_high <= skid_high;
      out_zero <= skid_zero;
      out_bad  <= skid_bad;
      out_done <= skid_done;
    end else if (xfer_in && (xfer_out || !out_valid)) begin
      out_low  <= res_low;
      out_high <= res_high;
      out_zero <= res_zero;
      out_bad  <= fail_next;
      out_done <= in_ch.end_of_set;
    end
    if (xfer_in && out_valid && !xfer_out) begin
      skid_low  <= res_low;
      skid_high <= res_high;
      skid_zero <= res_zero;
      skid_bad  <= fail_next;
      skid_done <= in_ch.end_of_set;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.range_low  = out_low;
  assign out_ch.range_high = out_high;
  assign out_ch.is_zero    = out_zero;
  assign out_ch.invalid    = out_bad;
  assign out_ch.set_done   = out_done;

endmodule

FILE: hw/rtl/art_checker.sv
// Port-level checker for the adaptive range tracker and its bind to the top level.
// Depends on art_pkg and adaptive_range_tracker_top.
module art_checker #(
  parameter int W = art_pkg::VALUE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] range_low,
  input logic [W-1:0] range_high,
  input logic         is_zero,
  input logic         invalid,
  input logic         set_done
);
  import art_pkg::*;

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(range_low) && $stable(range_high) &&
      $stable(is_zero) && $stable(invalid) && $stable(set_done))
    else $error("result payload changed while stalled");

  // A failed set reports an empty range.
  a_invalid_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> (range_low == '0) && (range_high == '0) && !is_zero)
    else $error("failed set result carries a range");

  // The zero flag goes with a 0..0 range.
  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_zero |-> (range_low == '0) && (range_high == '0) && !invalid)
    else $error("zero flag with a nonzero range");

  // Any other result is a proper range, since degenerate ranges are widened.
  a_proper_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_zero && !invalid |-> range_low < range_high)
    else $error("reported range is not proper");

endmodule

bind adaptive_range_tracker_top art_checker #(.W(VALUE_BITS)) u_art_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .range_low  (out_ch.range_low),
  .range_high (out_ch.range_high),
  .is_zero    (out_ch.is_zero),
  .invalid    (out_ch.invalid),
  .set_done   (out_ch.set_done)
);

FILE: bench/art_range_checker.sv
// Result checker for the adaptive range tracker.
// Watches both channels and the margin write port, predicts each result and compares it.
// Depends on art_pkg and on the art_in_if / art_out_if channel interfaces.
module art_range_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [art_pkg::MARGIN_BITS-1:0] cfg_wdata,
  art_in_if                           in_mon,
  art_out_if                          out_mon,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  localparam int W = VALUE_BITS_DEF;
  localparam logic [W-1:0] VMAX = '1;

  typedef logic [W+1:0] wide_t;

  typedef struct packed {
    logic [W-1:0] lo;
    logic [W-1:0] hi;
    logic         zero;
    logic         bad;
    logic         done;
  } range_result_t;

  logic [MARGIN_BITS-1:0] margin;
  logic [W-1:0]           track_lo;
  logic [W-1:0]           track_hi;
  logic                   set_open;
  logic                   set_bad;
  range_result_t          range_q[$];
  int                     miss_count;

  function automatic logic [W-1:0] clamp_high(wide_t x);
    return (x > wide_t'(VMAX)) ? VMAX : x[W-1:0];
  endfunction

  function automatic logic [W-1:0] floor_sub(wide_t a, wide_t b);
    wide_t diff;
    diff = a - b;
    return (a >= b) ? diff[W-1:0] : '0;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    miss_count++;
    if (miss_count <= 40)
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Updates the tracked range with one item and queues the result it should produce.
  task automatic advance_range(input logic iv, input logic [W-1:0] a,
                               input logic [W-1:0] b, input logic last);
    wide_t         d;
    range_result_t r;
    if (!set_bad) begin
      if (iv) begin
        if (a >= b) begin
          set_bad = 1'b1;
        end else begin
          if (!set_open || a < track_lo) track_lo = a;
          if (!set_open || b > track_hi) track_hi = b;
          set_open = 1'b1;
        end
      end else begin
        if (!set_open) begin
          track_lo = floor_sub(wide_t'(a), wide_t'(margin));
          track_hi = clamp_high(wide_t'(a) + wide_t'(margin));
        end else if (track_lo == track_hi && a != track_lo) begin
          // A single point spreads half the distance above it and below min(point, value).
          if (a < track_lo) begin
            d = wide_t'(track_lo) - wide_t'(a);
            track_lo = floor_sub(wide_t'(a), d >> 1);
          end else begin
            d = wide_t'(a) - wide_t'(track_lo);
            track_lo = floor_sub(wide_t'(track_lo), d >> 1);
          end
          track_hi = clamp_high(wide_t'(track_hi) + (d >> 1));
        end else if (a < track_lo) begin
          d = wide_t'(track_lo) - wide_t'(a);
          track_lo = floor_sub(wide_t'(a), d);
        end else if (a > track_hi) begin
          d = wide_t'(a) - wide_t'(track_hi);
          track_hi = clamp_high(wide_t'(a) + d);
        end
        set_open = 1'b1;
      end
    end

    r.lo   = '0;
    r.hi   = '0;
    r.zero = 1'b0;
    r.bad  = 1'b0;
    r.done = last;
    if (set_bad) begin
      r.bad = 1'b1;
    end else if (track_lo == '0 && track_hi == '0) begin
      r.zero = 1'b1;
    end else if (track_lo == track_hi) begin
      r.lo = floor_sub(wide_t'(track_lo), wide_t'(1));
      r.hi = clamp_high(wide_t'(track_hi) + wide_t'(1));
    end else begin
      r.lo = track_lo;
      r.hi = track_hi;
    end
    range_q.push_back(r);

    if (last) begin
      set_open = 1'b0;
      set_bad  = 1'b0;
    end
  endtask

  always @(posedge clk) begin : monitor
    range_result_t want;
    if (rst) begin
      margin     = MARGIN_RESET;
      track_lo   = '0;
      track_hi   = '0;
      set_open   = 1'b0;
      set_bad    = 1'b0;
      miss_count = 0;
      range_q.delete();
    end else begin
      if (cfg_we) margin = cfg_wdata;
      // The result leaving now is older than any item entering at this edge.
      if (out_mon.valid && out_mon.ready) begin
        if (range_q.size() == 0) begin
          report_mismatch("unexpected result", out_mon.range_low, '0);
        end else begin
          want = range_q.pop_front();
          if (out_mon.range_low !== want.lo)
            report_mismatch("range_low", out_mon.range_low, want.lo);
          if (out_mon.range_high !== want.hi)
            report_mismatch("range_high", out_mon.range_high, want.hi);
          if (out_mon.is_zero !== want.zero)
            report_mismatch("is_zero", W'(out_mon.is_zero), W'(want.zero));
          if (out_mon.invalid !== want.bad)
            report_mismatch("invalid", W'(out_mon.invalid), W'(want.bad));
          if (out_mon.set_done !== want.done)
            report_mismatch("set_done", W'(out_mon.set_done), W'(want.done));
        end
      end
      if (in_mon.valid && in_mon.ready)
        advance_range(in_mon.is_interval, in_mon.first_value, in_mon.second_value,
                      in_mon.end_of_set);
    end
    mismatches  <= miss_count;
    outstanding <= range_q.size();
  end

endmodule

FILE: bench/adaptive_range_tracker_top_test.sv
// Top of the adaptive range tracker testbench: clock, reset, stimulus and verdict.
// Depends on art_pkg, the channel interfaces, the tracker RTL and art_range_checker.
module adaptive_range_tracker_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  localparam int W = VALUE_BITS_DEF;
  localparam logic [W-1:0] VMAX = '1;
  // Length of the one long stall of the result side, in cycles.
  localparam int HOLD_CYCLES = 80;
  // Minimum number of random items per margin setting.
  localparam int PHASE_ITEMS = 190;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [MARGIN_BITS-1:0] cfg_wdata;
  int                     mismatches;
  int                     outstanding;

  // Requests the long hold-off on the result side; cleared gaps while it is pending.
  bit squeeze_req;
  bit squeeze_done;
  // When set, neither side inserts idle cycles.
  bit full_rate;

  art_in_if  #(.W(W)) in_ch ();
  art_out_if #(.W(W)) out_ch ();

  adaptive_range_tracker_top #(.VALUE_BITS(W)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  art_range_checker range_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length between transfers: mostly none, sometimes a few cycles, rarely a long one.
  // No gaps are made while the long stall is pending, so the tracker fills up.
  function automatic int pick_gap();
    int r;
    if (full_rate || (squeeze_req && !squeeze_done)) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // A value for a set: mostly close to the set's base so that ranges get
  // extended in small steps, with some extremes and some fully random values.
  function automatic logic [W-1:0] pick_value(int base);
    int           r;
    int           v;
    logic [W-1:0] raw;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return VMAX;
    if (r < 30) begin
      raw = $urandom;
      return raw;
    end
    v = base + $urandom_range(0, 80) - 40;
    if (v < 0) v = 0;
    if (v > int'(VMAX)) v = int'(VMAX);
    return v[W-1:0];
  endfunction

  // Offers one item and returns after its transfer, followed by a random idle gap.
  task automatic send_item(input logic iv, input logic [W-1:0] a, input logic [W-1:0] b,
                           input logic last);
    int n;
    in_ch.valid        <= 1'b1;
    in_ch.is_interval  <= iv;
    in_ch.first_value  <= a;
    in_ch.second_value <= b;
    in_ch.end_of_set   <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n = pick_gap();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // One set of random items. Most items are single values around a base;
  // some are well-formed intervals and a few are malformed ones that spoil the set.
  task automatic send_random_set(input int len);
    int           base;
    int           r;
    int           t;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         iv;
    r = $urandom_range(2);
    if (r == 0) base = $urandom_range(0, 30);
    else if (r == 1) base = int'(VMAX) - $urandom_range(0, 30);
    else base = $urandom_range(0, int'(VMAX));
    for (int k = 0; k < len; k++) begin
      r  = $urandom_range(99);
      a  = pick_value(base);
      b  = $urandom;
      iv = 1'b0;
      if (r < 12) begin
        iv = 1'b1;
        if (a == VMAX) a = a - 1'b1;
        t = int'(a) + $urandom_range(1, 300);
        if (t > int'(VMAX)) t = int'(VMAX);
        b = t[W-1:0];
      end else if (r < 15) begin
        // Low bound not below the high bound.
        iv = 1'b1;
        t  = int'(a) - $urandom_range(0, 40);
        if (t < 0) t = 0;
        b = t[W-1:0];
      end
      send_item(iv, a, b, k == len - 1);
    end
  endtask

  // Stops offering and waits until every queued result has been checked.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the margin register; only called while the tracker is idle.
  task automatic set_margin(input logic [MARGIN_BITS-1:0] m);
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random ready pattern, plus one long hold-off when requested.
  initial begin : result_side
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Item side: reset, directed items, then random sets under several margins.
  initial begin : item_side
    logic [MARGIN_BITS-1:0] margins[5];
    int                     sent;
    int                     len;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.is_interval  <= 1'b0;
    in_ch.first_value  <= '0;
    in_ch.second_value <= '0;
    in_ch.end_of_set   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset margin of 5.
    // A first value of zero floors the low bound at zero.
    send_item(1'b0, '0, VMAX, 1'b1);
    // A first value at the maximum saturates the high bound; a far value below
    // then pulls the low bound down to zero.
    send_item(1'b0, VMAX, '0, 1'b0);
    send_item(1'b0, 16'd3, '0, 1'b1);
    // Intervals open and widen the range, then values extend each side by
    // twice their distance, and a value inside changes nothing.
    send_item(1'b1, 16'd10, 16'd20, 1'b0);
    send_item(1'b1, 16'd5, 16'd30, 1'b0);
    send_item(1'b0, 16'd40, '0, 1'b0);
    send_item(1'b0, 16'd2, '0, 1'b0);
    send_item(1'b0, 16'd25, '0, 1'b1);
    // The widest interval.
    send_item(1'b1, '0, VMAX, 1'b1);
    // A malformed interval as the first item spoils the rest of the set.
    send_item(1'b1, 16'd20, 16'd20, 1'b0);
    send_item(1'b0, 16'd7, '0, 1'b0);
    send_item(1'b1, 16'd1, 16'd9, 1'b1);
    // A malformed interval later in a set, then a fresh set after it ends.
    send_item(1'b0, 16'd100, '0, 1'b0);
    send_item(1'b1, VMAX, '0, 1'b1);
    send_item(1'b0, 16'd50, '0, 1'b1);
    drain();

    // With a zero margin single values give a single-point range.
    set_margin('0);
    // A range of exactly zero.
    send_item(1'b0, '0, '0, 1'b1);
    // Zero repeated, then growth from a point at zero.
    send_item(1'b0, '0, '0, 1'b0);
    send_item(1'b0, '0, '0, 1'b0);
    send_item(1'b0, 16'd8, '0, 1'b1);
    // Growth upward from a point leaves the high bound below the value.
    send_item(1'b0, 16'd100, '0, 1'b0);
    send_item(1'b0, 16'd110, '0, 1'b0);
    send_item(1'b0, 16'd120, '0, 1'b1);
    // Growth downward from a point.
    send_item(1'b0, 16'd100, '0, 1'b0);
    send_item(1'b0, 16'd90, '0, 1'b1);
    // A point at the maximum is widened with saturation; a neighbor one below
    // gives half a distance of zero.
    send_item(1'b0, VMAX, '0, 1'b0);
    send_item(1'b0, VMAX - 1'b1, '0, 1'b1);
    drain();

    // Random sets: both margin extremes, two random margins, and a margin of one.
    // The third setting carries the long stall, the last one runs with no idling.
    margins[0] = '0;
    margins[1] = '1;
    margins[2] = MARGIN_BITS'($urandom_range(255));
    margins[3] = MARGIN_BITS'($urandom_range(255));
    margins[4] = 8'd1;
    for (int p = 0; p < 5; p++) begin
      set_margin(margins[p]);
      if (p == 2) squeeze_req = 1'b1;
      full_rate = (p == 4);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) len = $urandom_range(10, 30);
        else len = $urandom_range(1, 8);
        send_random_set(len);
        sent += len;
      end
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/art_pkg.sv
hw/rtl/art_if.sv
hw/rtl/adaptive_range_tracker_top.sv
hw/rtl/art_checker.sv
bench/art_range_checker.sv
bench/adaptive_range_tracker_top_test.sv
